FILE: design/gray_conv3x3_stream_unit_defines.svh
// Assertion macros shared by the gray/3x3 convolution stream unit.
// Included by the top level only; no other dependencies.
`ifndef GRAY_CONV3X3_STREAM_UNIT_DEFINES_SVH
`define GRAY_CONV3X3_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gcs_pkg.sv
// Shared types and constants of the gray/3x3 convolution stream unit.
// No dependencies; imported by every module of the block.
package gcs_pkg;

    localparam int PIX_W     = 8;
    localparam int IMG_W     = 11;
    localparam int KTOP_W    = 48;
    localparam int KBOT_W    = 24;
    localparam int CFG_DW    = 48;
    localparam int CFG_AW    = 2;
    localparam int ROW_W     = 2;
    localparam int PROD_W    = 17;
    localparam int SUM_W     = 21;
    localparam int FIFO_AW   = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Luma weights in units of 1/256.
    localparam logic [7:0] W_FIRST  = 8'd77;
    localparam logic [7:0] W_SECOND = 8'd148;
    localparam logic [7:0] W_THIRD  = 8'd28;

    localparam logic [IMG_W-1:0]  WIDTH_RST = 11'd640;
    localparam logic [KTOP_W-1:0] KTOP_RST  = 48'h0001_0000_0000;
    localparam logic [KBOT_W-1:0] KBOT_RST  = 24'h00_0000;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE  = 2'd0,
        CFG_WIDTH = 2'd1,
        CFG_KTOP  = 2'd2,
        CFG_KBOT  = 2'd3
    } t_cfg_idx;

    // Pixel entering the line store stage.
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] gray;
    } t_s1;

    // Pixel past the line store stage.
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] gray;
    } t_s2;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             clipped;
    } t_res;

    // [kernel row][kernel column], column 2 is the newest pixel.
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;
    typedef logic [8:0][PIX_W-1:0]      t_coefs;

endpackage

FILE: design/gcs_ifs.sv
// Stream and configuration channel interfaces of the gray/3x3 unit.
// Depends on nothing; payload widths follow the block's field list.
interface gcs_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       start_of_frame;
    modport source (output valid, first_byte, second_byte, third_byte, start_of_frame,
                    input ready);
    modport sink   (input valid, first_byte, second_byte, third_byte, start_of_frame,
                    output ready);
endinterface

interface gcs_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic       clipped;
    modport source (output valid, level, clipped, input ready);
    modport sink   (input valid, level, clipped, output ready);
endinterface

interface gcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/gcs_line_buf.sv
// Line store memory and 3x3 window of the gray/3x3 unit.
// Depends on gcs_pkg. One 16-bit entry per column holds {row r-2, row r-1}.
module gcs_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_col,
    input  gcs_pkg::t_s1                  i_s1,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_s1_col,
    output gcs_pkg::t_win                 o_win,
    output gcs_pkg::t_s2                  o_s2
);
    import gcs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_q;
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] r_fwd_data;
    t_win               r_win;
    t_win               n_win;
    t_s2                r_s2;

    logic [2*PIX_W-1:0] w_data;
    logic [2*PIX_W-1:0] w_wdata;
    logic [PIX_W-1:0]   w_top;
    logic [PIX_W-1:0]   w_mid;

    // The previous pixel writes at the edge this one reads: take its data instead.
    assign w_data  = r_fwd_hit ? r_fwd_data : r_q;
    assign w_top   = (i_s1.row >= ROW_W'(2)) ? w_data[2*PIX_W-1:PIX_W] : '0;
    assign w_mid   = (i_s1.row >= ROW_W'(1)) ? w_data[PIX_W-1:0] : '0;
    assign w_wdata = {w_data[PIX_W-1:0], i_s1.gray};

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_col];
        end
        if (i_s1.valid) begin
            r_mem[i_s1_col] <= w_wdata;
        end
        r_fwd_data <= w_wdata;
    end

    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            if (i_s1_col == CW'(0)) begin
                n_win[k][0] = '0;
                n_win[k][1] = '0;
            end else begin
                n_win[k][0] = r_win[k][1];
                n_win[k][1] = r_win[k][2];
            end
        end
        n_win[0][2] = w_top;
        n_win[1][2] = w_mid;
        n_win[2][2] = i_s1.gray;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
            r_win     <= '0;
            r_s2      <= '0;
        end else begin
            r_fwd_hit   <= i_rd_en && i_s1.valid && (i_s1_col == i_rd_col);
            r_s2.valid  <= i_s1.valid;
            r_s2.gray   <= i_s1.gray;
            if (i_s1.valid) begin
                r_win <= n_win;
            end
        end
    end

    assign o_win = r_win;
    assign o_s2  = r_s2;

endmodule

FILE: design/gcs_kernel.sv
// Signed 3x3 kernel products, sum and saturation of the gray/3x3 unit.
// Depends on gcs_pkg. Two register stages: products, then the clipped sum (or the gray value when i_mode is low).
module gcs_kernel (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mode,
    input  gcs_pkg::t_coefs i_coefs,
    input  gcs_pkg::t_win   i_win,
    input  gcs_pkg::t_s2    i_s2,
    output logic            o_push,
    output gcs_pkg::t_res   o_res
);
    import gcs_pkg::*;

    logic signed [PROD_W-1:0] r_prod [9];
    t_s2                      r_s3;
    logic                     r_push;
    t_res                     r_res;
    logic signed [SUM_W-1:0]  w_sum;
    t_res                     w_res;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_prod[i] <= PROD_W'($signed(i_coefs[i]))
                       * PROD_W'($signed({1'b0, i_win[i/3][i%3]}));
        end
    end

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 9; i++) begin
            w_sum = w_sum + SUM_W'(r_prod[i]);
        end
        if (!i_mode) begin
            w_res.level   = r_s3.gray;
            w_res.clipped = 1'b0;
        end else if (w_sum < 0) begin
            w_res.level   = '0;
            w_res.clipped = 1'b1;
        end else if (w_sum > SUM_W'(255)) begin
            w_res.level   = '1;
            w_res.clipped = 1'b1;
        end else begin
            w_res.level   = w_sum[PIX_W-1:0];
            w_res.clipped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3   <= '0;
            r_push <= 1'b0;
        end else begin
            r_s3   <= i_s2;
            r_push <= r_s3.valid;
        end
        r_res <= w_res;
    end

    assign o_push = r_push;
    assign o_res  = r_res;

endmodule

FILE: design/gcs_out_fifo.sv
// Output queue with credit count for the gray/3x3 unit.
// Depends on gcs_pkg and gcs_res_if. Credits cover the pipeline plus the queue.
module gcs_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_push,
    input  gcs_pkg::t_res    i_res,
    output logic             o_room,
    gcs_res_if.source        o_res
);
    import gcs_pkg::*;

    t_res               r_buf [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_fill;
    logic [FIFO_AW:0]   r_credit;
    logic               w_pop;

    assign w_pop   = o_res.valid && o_res.ready;
    assign o_room  = r_credit < (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_res.valid   = r_fill != '0;
    assign o_res.level   = r_buf[r_rd].level;
    assign o_res.clipped = r_buf[r_rd].clipped;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            r_fill   <= r_fill + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(w_pop);
            r_credit <= r_credit + (FIFO_AW+1)'(i_take) - (FIFO_AW+1)'(w_pop);
        end
    end

endmodule

FILE: design/gray_conv3x3_stream_unit.sv
// Gray conversion with optional signed 3x3 convolution, one pixel per clock while output credits remain.
// Result path: input register, line store window, kernel products, kernel result, output queue.
// Throughput: one pixel per cycle; an 8-entry output queue with credits sets how far
// a stalled output lets the input run ahead. Line store entries are read at the
// accepting edge and written back at the next edge, with forwarding between pixels.
// Reset clears counters, window, queue and config; line store contents stay undefined.
`include "gray_conv3x3_stream_unit_defines.svh"
module gray_conv3x3_stream_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcs_pix_if.sink    i_pix,
    gcs_res_if.source  o_res,
    gcs_cfg_if.sink    i_cfg
);
    import gcs_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > IMG_W) ? CW + 1 : IMG_W;

    logic              r_mode;
    logic [IMG_W-1:0]  r_width;
    logic [KTOP_W-1:0] r_ktop;
    logic [KBOT_W-1:0] r_kbot;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    t_s1               r_s1;
    logic [CW-1:0]     r_s1_col;

    logic              w_take;
    logic              w_room;
    logic [CW-1:0]     w_col;
    logic [ROW_W-1:0]  w_row;
    logic [CMPW-1:0]   w_eff;
    logic              w_eol;
    logic [15:0]       w_luma;
    t_coefs            w_coefs;
    t_win              w_win;
    t_s2               w_s2;
    logic              w_push;
    t_res              w_res;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = w_room;
    assign w_take      = i_pix.valid && w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_width <= WIDTH_RST;
            r_ktop  <= KTOP_RST;
            r_kbot  <= KBOT_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_MODE:  r_mode  <= i_cfg.data[0];
                CFG_WIDTH: r_width <= i_cfg.data[IMG_W-1:0];
                CFG_KTOP:  r_ktop  <= i_cfg.data[KTOP_W-1:0];
                CFG_KBOT:  r_kbot  <= i_cfg.data[KBOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_coefs[i] = r_ktop[8*i +: 8];
        end
        for (int i = 0; i < 3; i++) begin
            w_coefs[6+i] = r_kbot[8*i +: 8];
        end
    end

    // Clamp the programmed width to 1..MAX_WIDTH.
    always_comb begin
        if (r_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_width);
        end
        w_col  = i_pix.start_of_frame ? '0 : r_col;
        w_row  = i_pix.start_of_frame ? '0 : r_row;
        w_eol  = (CMPW'(w_col) + CMPW'(1)) >= w_eff;
        w_luma = 16'(W_FIRST) * 16'(i_pix.first_byte)
               + 16'(W_SECOND) * 16'(i_pix.second_byte)
               + 16'(W_THIRD) * 16'(i_pix.third_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else begin
            r_s1.valid <= w_take;
            if (w_take) begin
                r_s1.row  <= w_row;
                r_s1.gray <= w_luma[15:8];
                if (w_eol) begin
                    r_col <= '0;
                    if (w_row < ROW_W'(2)) begin
                        r_row <= w_row + ROW_W'(1);
                    end else begin
                        r_row <= w_row;
                    end
                end else begin
                    r_col <= w_col + CW'(1);
                    r_row <= w_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_col <= w_col;
        end
    end

    gcs_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_take),
        .i_rd_col (w_col),
        .i_s1     (r_s1),
        .i_s1_col (r_s1_col),
        .o_win    (w_win),
        .o_s2     (w_s2)
    );

    gcs_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_coefs (w_coefs),
        .i_win   (w_win),
        .i_s2    (w_s2),
        .o_push  (w_push),
        .o_res   (w_res)
    );

    gcs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_res   (o_res)
    );

    `GCS_ASSERT_NEXT(a_take_enters_pipe, i_clk, i_rst_n, w_take, r_s1.valid, "accepted pixel missing from line store stage")
    `GCS_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, 1'b1, {1'b0, r_col} < (CW+1)'(MAX_WIDTH), "column count beyond line store depth")
    `GCS_ASSERT_NOW(a_full_credit_has_result, i_clk, i_rst_n, !w_room, o_res.valid, "credits exhausted while output queue is empty")

endmodule
